### rtl/device_address_table_macros.svh
// ----------------------------------------------------------------------------
// device address table assertion macros
// concurrent assertion wrappers, compiled out when ASSERT_OFF is defined
// ----------------------------------------------------------------------------
`ifndef DEVICE_ADDRESS_TABLE_MACROS_SVH
`define DEVICE_ADDRESS_TABLE_MACROS_SVH

`ifndef ASSERT_OFF
// condition must hold in the same cycle as the trigger
`define DAT_ASSERT_SAME(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("device address table check failed");
// condition must hold in the cycle after the trigger
`define DAT_ASSERT_NEXT(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("device address table check failed");
`else
`define DAT_ASSERT_SAME(label, clk, rst_n, trig, cond)
`define DAT_ASSERT_NEXT(label, clk, rst_n, trig, cond)
`endif

`endif

### rtl/dat_pkg.sv
// ----------------------------------------------------------------------------
// dat_pkg
// widths, codes, reset values and record types of the device address table
// ----------------------------------------------------------------------------
package dat_pkg;

    localparam int MAX_DEVICES = 16;
    localparam int IDX_W       = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
    localparam int FILL_W      = $clog2(MAX_DEVICES + 1);

    localparam int MAC_W       = 48;
    localparam int IP_W        = 32;
    localparam int HOST_W      = 8;
    localparam int PREFIX_W    = 24;
    localparam int KIND_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int ENTRY_W     = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int IN_DATA_W   = 80;
    localparam int OUT_DATA_W  = 152;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_ADD     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ASSIGN  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FIND_MAC = 2'd2;
    localparam logic [KIND_W-1:0] KIND_FIND_IP = 2'd3;

    // result status
    localparam logic [STATUS_W-1:0] STAT_OK             = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND      = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_POOL_EXHAUSTED = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_TABLE_FULL     = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_FIRST = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_LAST  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PREFIX     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GATEWAY    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SUBNET     = 3'd4;

    // reset values (192.168.1.x pool)
    localparam logic [HOST_W-1:0]   RST_FIRST_HOST = 8'd1;
    localparam logic [HOST_W-1:0]   RST_LAST_HOST  = 8'd254;
    localparam logic [PREFIX_W-1:0] RST_PREFIX     = 24'hC0A801;
    localparam logic [IP_W-1:0]     RST_GATEWAY    = 32'hC0A80107;
    localparam logic [IP_W-1:0]     RST_SUBNET     = 32'hFFFFFF00;

    // one table row
    typedef struct packed {
        logic [MAC_W-1:0] mac;
        logic [IP_W-1:0]  address;
        logic [IP_W-1:0]  subnet;
        logic [IP_W-1:0]  gateway;
    } row_t;

    // result word, status in the lowest bits
    typedef struct packed {
        logic                has_address;
        logic [IP_W-1:0]     gateway;
        logic [IP_W-1:0]     subnet;
        logic [IP_W-1:0]     address;
        logic [MAC_W-1:0]    mac;
        logic [ENTRY_W-1:0]  entry_index;
        logic [STATUS_W-1:0] status;
    } result_t;

endpackage

### rtl/device_address_table.sv
// ----------------------------------------------------------------------------
// device_address_table
// table of devices keyed by mac, with a pool address allocator and
// lookups by mac or by ip
// ----------------------------------------------------------------------------
//  channel   direction  handshake           content
//  s_*       in         s_tvalid/s_tready   tuser: kind; tdata: mac, ip_query
//  m_*       out        m_tvalid/m_tready   tdata: status .. out_has_address
//  cfg_*     in         cfg_wen             cfg_index, cfg_data
//
//  add, or a search of an empty table: no scan; search or assignment: the
//  entries are scanned newest first (up to 16), one table row read and one
//  shared compare per cycle
//  reset is asynchronous, active low; it clears the has-address bits and the
//  fill count and reloads the pool counter, but not the table rows
//  s_tready is high only while idle; a finished result waits while m_tready is low
// ----------------------------------------------------------------------------
`include "device_address_table_macros.svh"

module device_address_table
    import dat_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration writes
    input  logic                  cfg_wen,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // request stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // mac[47:0], ip_query[79:48]
    input  logic [KIND_W-1:0]     s_tuser,   // kind[1:0]
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata    // status[1:0], entry_index[5:2],
                                             // out_mac[53:6], out_address[85:54],
                                             // out_subnet[117:86],
                                             // out_gateway[149:118],
                                             // out_has_address[150], zero[151]
);

    // sequencer states
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_FINISH = 2'd1;
    localparam logic [1:0] ST_SCAN   = 2'd2;

    logic [1:0]             state_reg, state_next;

    // latched request
    logic [KIND_W-1:0]      kind_reg;
    logic [MAC_W-1:0]       mac_reg;
    logic [IP_W-1:0]        ip_reg;

    // scan pointer: slot whose row sits in rd_row_reg
    logic [IDX_W-1:0]       idx_reg, idx_next;

    // table state
    logic [FILL_W-1:0]      fill_count_reg;
    logic [HOST_W-1:0]      next_host_reg;
    logic [MAX_DEVICES-1:0] has_reg;

    // configuration
    logic [HOST_W-1:0]      pool_last_reg;
    logic [PREFIX_W-1:0]    prefix_reg;
    logic [IP_W-1:0]        gateway_reg;
    logic [IP_W-1:0]        subnet_reg;

    // table memory
    row_t                   table_mem [MAX_DEVICES];
    row_t                   rd_row_reg;

    // output register
    result_t                out_reg;
    logic                   m_valid_reg;

    // sequencer controls
    logic                   accept;
    logic                   out_free;
    logic                   table_full;
    logic                   hit;
    logic                   scan_end;
    logic                   pool_room;
    logic [IDX_W-1:0]       last_slot;
    logic [IDX_W-1:0]       fill_slot;
    logic                   rd_en;
    logic [IDX_W-1:0]       rd_addr;
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    row_t                   wr_row;
    logic                   set_has;
    logic                   clr_has;
    logic                   fill_inc;
    logic                   host_step;
    logic                   res_load;
    result_t                res;

    assign s_tready   = (state_reg == ST_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign out_free   = !m_valid_reg || m_tready;
    assign table_full = (fill_count_reg == FILL_W'(MAX_DEVICES));
    assign last_slot  = IDX_W'(fill_count_reg - FILL_W'(1));
    assign fill_slot  = IDX_W'(fill_count_reg);
    assign pool_room  = (next_host_reg < pool_last_reg);

    // the one comparator, shared by both kinds of search
    assign hit = (kind_reg == KIND_FIND_IP) ?
                 (has_reg[idx_reg] && (rd_row_reg.address == ip_reg)) :
                 (rd_row_reg.mac == mac_reg);

    // stop on a hit or after the oldest slot
    assign scan_end = hit || (idx_reg == '0);

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        rd_en      = 1'b0;
        rd_addr    = idx_reg - IDX_W'(1);
        wr_en      = 1'b0;
        wr_addr    = idx_reg;
        wr_row     = '0;
        set_has    = 1'b0;
        clr_has    = 1'b0;
        fill_inc   = 1'b0;
        host_step  = 1'b0;
        res_load   = 1'b0;
        res        = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    // fetch the newest row straight away
                    rd_en    = 1'b1;
                    rd_addr  = last_slot;
                    idx_next = last_slot;
                    if ((s_tuser == KIND_ADD) || (fill_count_reg == '0))
                        state_next = ST_FINISH;
                    else
                        state_next = ST_SCAN;
                end
            end

            ST_FINISH:
            begin
                // add, or a search of an empty table
                if (out_free)
                begin
                    res_load   = 1'b1;
                    state_next = ST_IDLE;
                    if (kind_reg == KIND_ADD)
                    begin
                        if (table_full)
                            res.status = STAT_TABLE_FULL;
                        else
                        begin
                            wr_en           = 1'b1;
                            wr_addr         = fill_slot;
                            wr_row.mac      = mac_reg;
                            clr_has         = 1'b1;
                            fill_inc        = 1'b1;
                            res.status      = STAT_OK;
                            res.entry_index = ENTRY_W'(fill_count_reg);
                            res.mac         = mac_reg;
                        end
                    end
                    else
                        res.status = STAT_NOT_FOUND;
                end
            end

            ST_SCAN:
            begin
                if (scan_end)
                begin
                    if (out_free)
                    begin
                        res_load   = 1'b1;
                        state_next = ST_IDLE;
                        if (!hit)
                            res.status = STAT_NOT_FOUND;
                        else
                        begin
                            res.status      = STAT_OK;
                            res.entry_index = ENTRY_W'(idx_reg);
                            res.mac         = rd_row_reg.mac;
                            res.address     = rd_row_reg.address;
                            res.subnet      = rd_row_reg.subnet;
                            res.gateway     = rd_row_reg.gateway;
                            res.has_address = has_reg[idx_reg];
                            if (kind_reg == KIND_ASSIGN)
                            begin
                                if (pool_room)
                                begin
                                    wr_en           = 1'b1;
                                    wr_row.mac      = rd_row_reg.mac;
                                    wr_row.address  = {prefix_reg, next_host_reg};
                                    wr_row.subnet   = subnet_reg;
                                    wr_row.gateway  = gateway_reg;
                                    set_has         = 1'b1;
                                    host_step       = 1'b1;
                                    res.address     = {prefix_reg, next_host_reg};
                                    res.subnet      = subnet_reg;
                                    res.gateway     = gateway_reg;
                                    res.has_address = 1'b1;
                                end
                                else
                                    res.status = STAT_POOL_EXHAUSTED;
                            end
                        end
                    end
                end
                else
                begin
                    // step to the next older slot
                    rd_en    = 1'b1;
                    idx_next = idx_reg - IDX_W'(1);
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // table memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            table_mem[wr_addr] <= wr_row;
        if (rd_en)
            rd_row_reg <= table_mem[rd_addr];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= s_tuser;
            mac_reg  <= s_tdata[MAC_W-1:0];
            ip_reg   <= s_tdata[MAC_W+IP_W-1:MAC_W];
        end
        idx_reg <= idx_next;
        if (res_load)
            out_reg <= res;
    end

    // control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            m_valid_reg    <= 1'b0;
            fill_count_reg <= '0;
            next_host_reg  <= RST_FIRST_HOST;
            has_reg        <= '0;
            pool_last_reg  <= RST_LAST_HOST;
            prefix_reg     <= RST_PREFIX;
            gateway_reg    <= RST_GATEWAY;
            subnet_reg     <= RST_SUBNET;
        end
        else
        begin
            state_reg <= state_next;

            if (res_load)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;

            if (fill_inc)
                fill_count_reg <= fill_count_reg + FILL_W'(1);
            if (set_has)
                has_reg[idx_reg] <= 1'b1;
            if (clr_has)
                has_reg[fill_slot] <= 1'b0;
            if (host_step)
                next_host_reg <= next_host_reg + HOST_W'(1);

            if (cfg_wen)
            begin
                case (cfg_index)
                    CFG_POOL_FIRST: next_host_reg <= cfg_data[HOST_W-1:0];
                    CFG_POOL_LAST:  pool_last_reg <= cfg_data[HOST_W-1:0];
                    CFG_PREFIX:     prefix_reg    <= cfg_data[PREFIX_W-1:0];
                    CFG_GATEWAY:    gateway_reg   <= cfg_data[IP_W-1:0];
                    CFG_SUBNET:     subnet_reg    <= cfg_data[IP_W-1:0];
                    default:        ;
                endcase
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, out_reg};

    // the fill count never passes the table depth
    `DAT_ASSERT_SAME(a_fill_bound, clk, rst_n, 1'b1, fill_count_reg <= FILL_W'(MAX_DEVICES))

    // a successful add grows the table by exactly one slot
    `DAT_ASSERT_NEXT(a_add_grows, clk, rst_n, fill_inc, fill_count_reg == $past(fill_count_reg) + FILL_W'(1))

    // a successful assignment steps the pool counter by one
    `DAT_ASSERT_NEXT(a_host_step, clk, rst_n, host_step && !cfg_wen, next_host_reg == $past(next_host_reg) + HOST_W'(1))

    // a result is only loaded while the sequencer is busy
    `DAT_ASSERT_SAME(a_load_busy, clk, rst_n, res_load, !s_tready)

endmodule
